[hdl/assert_macros.svh]
// Assertion macros shared by the RTL files. They expect clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define LSR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define LSR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/lsr_pkg.sv]
// ----------------------------------------------------------------------------
// lsr_pkg
// Types, constants and signature tables of the loader signature recognizer.
// ----------------------------------------------------------------------------
package lsr_pkg;

  localparam int STORE_BYTES = 65536;
  localparam int AW = $clog2(STORE_BYTES);

  localparam logic [15:0] BLOCK_START    = 16'h0316;
  localparam logic [15:0] BLOCK_MIN_END  = 16'h0570;
  localparam logic [15:0] END_MARK_START = 16'hfffc;
  localparam logic [15:0] END_MARK_END   = 16'hfffe;
  localparam logic [15:0] WIN1_FIRST     = 16'd234;
  localparam logic [15:0] WIN1_LAST      = 16'd402;
  localparam logic [15:0] WIN2_FIRST     = 16'd423;
  localparam logic [15:0] TAIL_BYTES     = 16'd23;

  localparam logic [7:0] KEY_LOW      = 8'h73;
  localparam logic [7:0] KEY_HIGH     = 8'h8a;
  localparam logic [7:0] KEY_BYTE_YES = 8'h08;
  localparam logic [7:0] KEY_BYTE_NO  = 8'h07;
  localparam logic [7:0] ORDER_MSB    = 8'h01;
  localparam logic [7:0] ORDER_LSB    = 8'h80;
  localparam logic [4:0] KEY_OFFSET   = 5'd29;

  localparam logic [1:0] ST_NOT_CHECKED = 2'd0;
  localparam logic [1:0] ST_CHECKED     = 2'd1;
  localparam logic [1:0] ST_END_FOUND   = 2'd2;

  localparam logic [2:0] K_CONST = 3'd0;
  localparam logic [2:0] K_CAPV  = 3'd1;
  localparam logic [2:0] K_EQA   = 3'd2;
  localparam logic [2:0] K_CAPA  = 3'd3;
  localparam logic [2:0] K_CAPB  = 3'd4;
  localparam logic [2:0] K_EQB   = 3'd5;
  localparam logic [2:0] K_CAPS  = 3'd6;
  localparam logic [2:0] K_KEY   = 3'd7;

  typedef struct packed {
    logic          header;
    logic          end_mark;
    logic          last;
    logic          wrong_block;
    logic [15:0]   len;
    logic [AW-1:0] addr;
    logic [7:0]    data;
  } lsr_cmd_t;

  typedef struct packed {
    logic [4:0] offset;
    logic [2:0] kind;
    logic [7:0] value;
    logic       final_step;
  } step_t;

  function automatic step_t mk(input logic [4:0] o, input logic [2:0] k,
                               input logic [7:0] v, input logic f);
    step_t s;
    s.offset = o;
    s.kind = k;
    s.value = v;
    s.final_step = f;
    return s;
  endfunction

  function automatic step_t scan_step(input logic second, input logic [4:0] idx);
    step_t s;
    s = mk(5'd0, K_CONST, 8'h00, 1'b1);
    if (!second) begin
      case (idx)
        5'd0:  s = mk(5'd18, K_CAPV,  8'h00, 1'b0);
        5'd1:  s = mk(5'd0,  K_CONST, 8'had, 1'b0);
        5'd2:  s = mk(5'd1,  K_CONST, 8'h00, 1'b0);
        5'd3:  s = mk(5'd2,  K_CONST, 8'h80, 1'b0);
        5'd4:  s = mk(5'd3,  K_CONST, 8'hee, 1'b0);
        5'd5:  s = mk(5'd4,  K_CONST, 8'h00, 1'b0);
        5'd6:  s = mk(5'd5,  K_CONST, 8'h80, 1'b0);
        5'd7:  s = mk(5'd6,  K_CONST, 8'hcd, 1'b0);
        5'd8:  s = mk(5'd7,  K_CONST, 8'h00, 1'b0);
        5'd9:  s = mk(5'd8,  K_CONST, 8'h80, 1'b0);
        5'd10: s = mk(5'd9,  K_CONST, 8'h26, 1'b0);
        5'd11: s = mk(5'd11, K_CONST, 8'h68, 1'b0);
        5'd12: s = mk(5'd12, K_CONST, 8'hc9, 1'b0);
        5'd13: s = mk(5'd13, K_CONST, 8'h61, 1'b0);
        5'd14: s = mk(5'd14, K_CONST, 8'hf0, 1'b0);
        5'd15: s = mk(5'd15, K_CONST, 8'h01, 1'b0);
        5'd16: s = mk(5'd16, K_CONST, 8'h18, 1'b0);
        5'd17: s = mk(5'd17, K_CONST, 8'h26, 1'b0);
        5'd18: s = mk(5'd10, K_EQA,   8'h00, 1'b0);
        5'd19: s = mk(5'd19, K_CONST, 8'ha5, 1'b0);
        5'd20: s = mk(5'd20, K_EQA,   8'h00, 1'b1);
        default: s = mk(5'd0, K_CONST, 8'h00, 1'b1);
      endcase
    end else begin
      case (idx)
        5'd0:  s = mk(5'd1,  K_CAPA,  8'h00, 1'b0);
        5'd1:  s = mk(5'd19, K_EQA,   8'h00, 1'b0);
        5'd2:  s = mk(5'd5,  K_CAPB,  8'h00, 1'b0);
        5'd3:  s = mk(5'd15, K_EQB,   8'h00, 1'b0);
        5'd4:  s = mk(5'd0,  K_CONST, 8'hc9, 1'b0);
        5'd5:  s = mk(5'd2,  K_CONST, 8'hd0, 1'b0);
        5'd6:  s = mk(5'd4,  K_CONST, 8'ha2, 1'b0);
        5'd7:  s = mk(5'd6,  K_CONST, 8'h86, 1'b0);
        5'd8:  s = mk(5'd7,  K_CONST, 8'hff, 1'b0);
        5'd9:  s = mk(5'd8,  K_CONST, 8'ha9, 1'b0);
        5'd10: s = mk(5'd10, K_CONST, 8'hd0, 1'b0);
        5'd11: s = mk(5'd12, K_CONST, 8'h90, 1'b0);
        5'd12: s = mk(5'd14, K_CONST, 8'ha2, 1'b0);
        5'd13: s = mk(5'd16, K_CONST, 8'h86, 1'b0);
        5'd14: s = mk(5'd17, K_CONST, 8'hff, 1'b0);
        5'd15: s = mk(5'd18, K_CONST, 8'hc9, 1'b0);
        5'd16: s = mk(5'd20, K_CONST, 8'hf0, 1'b0);
        5'd17: s = mk(5'd22, K_CONST, 8'hc9, 1'b0);
        5'd18: s = mk(5'd23, K_CAPS,  8'h00, 1'b0);
        5'd19: s = mk(KEY_OFFSET, K_KEY, 8'h00, 1'b1);
        default: s = mk(5'd0, K_CONST, 8'h00, 1'b1);
      endcase
    end
    return s;
  endfunction

  function automatic logic [7:0] key_lookup(input logic [4:0] i);
    logic [7:0] k;
    case (i)
      5'd0:  k = 8'h98;  5'd1:  k = 8'he8;  5'd2:  k = 8'h60;  5'd3:  k = 8'h08;
      5'd4:  k = 8'h98;  5'd5:  k = 8'hec;  5'd6:  k = 8'hb4;  5'd7:  k = 8'h04;
      5'd8:  k = 8'h08;  5'd9:  k = 8'h24;  5'd10: k = 8'he8;  5'd11: k = 8'hc0;
      5'd12: k = 8'h28;  5'd13: k = 8'h24;  5'd14: k = 8'h80;  5'd15: k = 8'hc0;
      5'd16: k = 8'hbc;  5'd17: k = 8'he0;  5'd18: k = 8'ha4;  5'd19: k = 8'hc0;
      5'd20: k = 8'he0;  5'd21: k = 8'ha4;  5'd22: k = 8'h40;  5'd23: k = 8'h80;
      default: k = 8'h00;
    endcase
    return k;
  endfunction

endpackage

[hdl/lsr_if.sv]
// ----------------------------------------------------------------------------
// lsr_in_if / lsr_out_if
// Valid/ready channels carrying input items and results.
// ----------------------------------------------------------------------------
interface lsr_in_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic [15:0] block_start;
  logic [15:0] block_end;
  logic [7:0]  data_byte;
  logic        last;
  modport source (output valid, mode, block_start, block_end, data_byte, last,
                  input ready);
  modport sink (input valid, mode, block_start, block_end, data_byte, last,
                output ready);
endinterface

interface lsr_out_if;
  logic       valid;
  logic       ready;
  logic       is_mine;
  logic       msb_first;
  logic       key_present;
  logic [7:0] pilot_val;
  logic [7:0] sync_byte;
  modport source (output valid, is_mine, msb_first, key_present, pilot_val,
                  sync_byte, input ready);
  modport sink (input valid, is_mine, msb_first, key_present, pilot_val,
                sync_byte, output ready);
endinterface

[hdl/lsr_front.sv]
// ----------------------------------------------------------------------------
// lsr_front
// Accepts input items, assigns store addresses and classifies each item.
// ----------------------------------------------------------------------------
module lsr_front (
  input  logic             clk,
  input  logic             rst_n,
  lsr_in_if.sink           in_ch,
  output logic             cmd_valid,
  input  logic             cmd_ready,
  output lsr_pkg::lsr_cmd_t cmd
);
  import lsr_pkg::*;

  logic [AW-1:0] wr_idx_r, wr_idx_nxt;
  logic          accept;

  assign in_ch.ready = cmd_ready;
  assign cmd_valid   = in_ch.valid;
  assign accept      = in_ch.valid && cmd_ready;

  always_comb begin
    cmd.header      = in_ch.mode;
    cmd.end_mark    = (in_ch.block_start == END_MARK_START)
                      && (in_ch.block_end == END_MARK_END);
    cmd.last        = in_ch.last;
    cmd.wrong_block = (in_ch.block_start != BLOCK_START)
                      || (in_ch.block_end < BLOCK_MIN_END);
    cmd.len         = in_ch.block_end - in_ch.block_start;
    cmd.addr        = wr_idx_r;
    cmd.data        = in_ch.data_byte;
  end

  always_comb begin
    wr_idx_nxt = wr_idx_r;
    if (accept) begin
      if (in_ch.mode || in_ch.last) begin
        wr_idx_nxt = '0;
      end else begin
        wr_idx_nxt = wr_idx_r + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_idx_r <= '0;
    end else begin
      wr_idx_r <= wr_idx_nxt;
    end
  end

endmodule

[hdl/lsr_queue.sv]
// ----------------------------------------------------------------------------
// lsr_queue
// Two-entry command queue between the front and the scan engine.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lsr_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  lsr_pkg::lsr_cmd_t push_cmd,
  output logic              can_push,
  output logic              pop_valid,
  input  logic              pop,
  output lsr_pkg::lsr_cmd_t pop_cmd
);
  import lsr_pkg::*;

  lsr_cmd_t   mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       do_push, do_pop;

  assign can_push  = (count_r != 2'd2);
  assign pop_valid = (count_r != 2'd0);
  assign pop_cmd   = mem_r[rd_ptr_r];
  assign do_push   = push && can_push;
  assign do_pop    = pop && pop_valid;

  always_comb begin
    wr_ptr_nxt = do_push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  `LSR_ASSERT_NOW(a_count_range, 1'b1, count_r <= 2'd2, "queue count out of range")

endmodule

[hdl/lsr_back.sv]
// ----------------------------------------------------------------------------
// lsr_back
// Byte store and signature scan engine with the result register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lsr_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cmd_valid,
  output logic              cmd_ready,
  input  lsr_pkg::lsr_cmd_t cmd,
  lsr_out_if.source         out_ch
);
  import lsr_pkg::*;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_ISSUE  = 2'd1;
  localparam logic [1:0] S_CHECK  = 2'd2;
  localparam logic [1:0] S_RESULT = 2'd3;

  logic [7:0] mem [STORE_BYTES];
  logic [7:0] rdata_r;
  logic [AW-1:0] raddr;
  logic [16:0] raddr_full;

  logic [1:0]  state_r, state_nxt;
  logic        scan2_r, scan2_nxt;
  logic [15:0] p_r, p_nxt;
  logic [4:0]  idx_r, idx_nxt;
  logic [15:0] limit_r, limit_nxt;
  logic [7:0]  a_r, a_nxt, b_r, b_nxt, s_r, s_nxt, key_r, key_nxt;
  logic        msb_r, msb_nxt, kp_r, kp_nxt;
  logic [1:0]  status_r, status_nxt;
  logic        f_msb_r, f_msb_nxt, f_kp_r, f_kp_nxt;
  logic [7:0]  f_pilot_r, f_pilot_nxt, f_sync_r, f_sync_nxt;
  logic        mine_r, mine_nxt;
  logic        res_valid_r, res_valid_nxt;
  logic        res_mine_r, res_msb_r, res_kp_r;
  logic [7:0]  res_pilot_r, res_sync_r;
  logic        res_load;

  step_t       st;
  logic [4:0]  off;
  logic [7:0]  x;
  logic        pass;
  logic        wr_en;

  assign st  = scan_step(scan2_r, idx_r);
  assign off = (st.kind == K_KEY) ? (KEY_OFFSET + {4'd0, msb_r}) : st.offset;
  assign raddr_full = {1'b0, p_r} + {12'd0, off};
  assign raddr = raddr_full[AW-1:0];
  assign x = rdata_r ^ (scan2_r ? key_r : 8'h00);
  assign wr_en = (state_r == S_IDLE) && cmd_valid && !cmd.header;
  assign cmd_ready = (state_r == S_IDLE);
  assign res_load = (state_r == S_RESULT) && (!res_valid_r || out_ch.ready);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[cmd.addr] <= cmd.data;
    end
    rdata_r <= mem[raddr];
  end

  always_comb begin
    pass  = 1'b0;
    a_nxt = a_r;
    b_nxt = b_r;
    s_nxt = s_r;
    msb_nxt = msb_r;
    kp_nxt  = kp_r;
    case (st.kind)
      K_CONST: pass = (x == st.value);
      K_CAPV: begin
        pass  = (rdata_r >= KEY_LOW) && (rdata_r <= KEY_HIGH);
        a_nxt = rdata_r;
      end
      K_EQA: pass = (rdata_r == a_r);
      K_CAPA: begin
        pass  = 1'b1;
        a_nxt = rdata_r;
      end
      K_CAPB: begin
        b_nxt   = rdata_r;
        pass    = (x == ORDER_MSB) || (x == ORDER_LSB);
        msb_nxt = (x == ORDER_MSB);
      end
      K_EQB: pass = (rdata_r == b_r);
      K_CAPS: begin
        pass  = 1'b1;
        s_nxt = x;
      end
      K_KEY: begin
        pass   = (x == KEY_BYTE_YES) || (x == KEY_BYTE_NO);
        kp_nxt = (x == KEY_BYTE_YES);
      end
      default: pass = 1'b0;
    endcase
    if (state_r != S_CHECK) begin
      a_nxt = a_r;
      b_nxt = b_r;
      s_nxt = s_r;
      msb_nxt = msb_r;
      kp_nxt  = kp_r;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    scan2_nxt   = scan2_r;
    p_nxt       = p_r;
    idx_nxt     = idx_r;
    limit_nxt   = limit_r;
    key_nxt     = key_r;
    status_nxt  = status_r;
    f_msb_nxt   = f_msb_r;
    f_kp_nxt    = f_kp_r;
    f_pilot_nxt = f_pilot_r;
    f_sync_nxt  = f_sync_r;
    mine_nxt    = mine_r;
    case (state_r)
      S_IDLE: begin
        if (cmd_valid) begin
          if (cmd.header) begin
            if (cmd.end_mark) begin
              status_nxt = ST_END_FOUND;
            end
          end else if (cmd.last) begin
            if (status_r == ST_CHECKED) begin
              mine_nxt  = 1'b1;
              state_nxt = S_RESULT;
            end else if (status_r == ST_END_FOUND || cmd.wrong_block) begin
              mine_nxt  = 1'b0;
              state_nxt = S_RESULT;
            end else begin
              scan2_nxt = 1'b0;
              p_nxt     = WIN1_FIRST;
              idx_nxt   = 5'd0;
              limit_nxt = cmd.len - TAIL_BYTES;
              state_nxt = S_ISSUE;
            end
          end
        end
      end
      S_ISSUE: state_nxt = S_CHECK;
      S_CHECK: begin
        if (!pass) begin
          idx_nxt = 5'd0;
          if ((!scan2_r && p_r == WIN1_LAST) || (scan2_r && p_r + 16'd1 >= limit_r)) begin
            mine_nxt  = 1'b0;
            state_nxt = S_RESULT;
          end else begin
            p_nxt     = p_r + 16'd1;
            state_nxt = S_ISSUE;
          end
        end else if (st.final_step) begin
          idx_nxt = 5'd0;
          if (!scan2_r) begin
            key_nxt   = key_lookup(5'(a_r - KEY_LOW));
            scan2_nxt = 1'b1;
            p_nxt     = WIN2_FIRST;
            if (WIN2_FIRST >= limit_r) begin
              mine_nxt  = 1'b0;
              state_nxt = S_RESULT;
            end else begin
              state_nxt = S_ISSUE;
            end
          end else begin
            f_msb_nxt   = msb_r;
            f_kp_nxt    = kp_nxt;
            f_pilot_nxt = a_r ^ key_r;
            f_sync_nxt  = s_r;
            status_nxt  = ST_CHECKED;
            mine_nxt    = 1'b1;
            state_nxt   = S_RESULT;
          end
        end else begin
          idx_nxt   = idx_r + 5'd1;
          state_nxt = S_ISSUE;
        end
      end
      S_RESULT: begin
        if (res_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    res_valid_nxt = res_valid_r;
    if (out_ch.ready) begin
      res_valid_nxt = 1'b0;
    end
    if (res_load) begin
      res_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      scan2_r     <= 1'b0;
      status_r    <= ST_NOT_CHECKED;
      f_msb_r     <= 1'b1;
      f_kp_r      <= 1'b1;
      f_pilot_r   <= 8'h00;
      f_sync_r    <= 8'h3d;
      key_r       <= 8'h00;
      res_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      scan2_r     <= scan2_nxt;
      status_r    <= status_nxt;
      f_msb_r     <= f_msb_nxt;
      f_kp_r      <= f_kp_nxt;
      f_pilot_r   <= f_pilot_nxt;
      f_sync_r    <= f_sync_nxt;
      key_r       <= key_nxt;
      res_valid_r <= res_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    p_r     <= p_nxt;
    idx_r   <= idx_nxt;
    limit_r <= limit_nxt;
    a_r     <= a_nxt;
    b_r     <= b_nxt;
    s_r     <= s_nxt;
    msb_r   <= msb_nxt;
    kp_r    <= kp_nxt;
    mine_r  <= mine_nxt;
    if (res_load) begin
      res_mine_r  <= mine_r;
      res_msb_r   <= mine_r & f_msb_r;
      res_kp_r    <= mine_r & f_kp_r;
      res_pilot_r <= mine_r ? f_pilot_r : 8'h00;
      res_sync_r  <= mine_r ? f_sync_r : 8'h00;
    end
  end

  assign out_ch.valid       = res_valid_r;
  assign out_ch.is_mine     = res_mine_r;
  assign out_ch.msb_first   = res_msb_r;
  assign out_ch.key_present = res_kp_r;
  assign out_ch.pilot_val   = res_pilot_r;
  assign out_ch.sync_byte   = res_sync_r;

  `LSR_ASSERT_NEXT(a_checked_sticky, status_r == ST_CHECKED, status_r != ST_NOT_CHECKED, "recognised status lost")
  `LSR_ASSERT_NOW(a_no_zero_fields, res_valid_r && !res_mine_r, !res_msb_r && !res_kp_r && res_pilot_r == 8'h00 && res_sync_r == 8'h00, "negative result carries findings")
  `LSR_ASSERT_NOW(a_idle_no_write_scan, state_r != S_IDLE, !wr_en, "store written during a scan")

endmodule

[hdl/loader_signature_recognizer.sv]
// ----------------------------------------------------------------------------
// loader_signature_recognizer
// Recognises a tape loader by scanning a stored block for its signature.
// ----------------------------------------------------------------------------
// Block bytes are taken at one per cycle while the queue has room, and go to a
// 64 KiB byte store through a two-entry command queue. The final byte of an
// undecided, well-formed block starts a scan of the store through its single
// read port, an issue and a check state per byte examined: the key window
// tries up to 169 positions of up to 21 bytes each, the decode pass up to 20
// bytes per position below the block length less 23. While a scan runs no new
// transaction is taken once the queue is full; each final block byte yields
// exactly one result, held in an output register until taken.
module loader_signature_recognizer (
  input logic       clk,
  input logic       rst_n,
  lsr_in_if.sink    in_ch,
  lsr_out_if.source out_ch
);
  import lsr_pkg::*;

  logic     f_valid, q_can_push, q_valid, q_pop;
  lsr_cmd_t f_cmd, q_cmd;

  lsr_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cmd_valid (f_valid),
    .cmd_ready (q_can_push),
    .cmd       (f_cmd)
  );

  lsr_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (f_valid),
    .push_cmd  (f_cmd),
    .can_push  (q_can_push),
    .pop_valid (q_valid),
    .pop       (q_pop),
    .pop_cmd   (q_cmd)
  );

  lsr_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (q_valid),
    .cmd_ready (q_pop),
    .cmd       (q_cmd),
    .out_ch    (out_ch)
  );

endmodule

[bench/tb_loader_signature_recognizer.sv]
// ----------------------------------------------------------------------------
// tb_loader_signature_recognizer
// Self-checking testbench for the loader signature recognizer.
// ----------------------------------------------------------------------------
// Block bytes and header events are sent over the input channel with random
// gaps while the result channel is stalled at random. A predictor in the
// testbench keeps its own copy of the byte store and the recognition state,
// works out the result of every final block byte and queues it; each result
// transaction is compared field by field with the oldest queued entry. The
// stimulus covers rejected blocks, a near miss of one signature scan, a full
// match with its sticky answer, and the end-marker header.
// ----------------------------------------------------------------------------
module tb_loader_signature_recognizer;
  timeunit 1ns;
  timeprecision 1ps;
  import lsr_pkg::*;

  localparam int CYCLE_LIMIT = 3000000;
  localparam int IMG_BYTES = 462;
  localparam int FILL_BYTES = 612;

  typedef enum int {FL_MATCH, FL_BAD_V, FL_BAD_ORDER, FL_BAD_KEYBYTE, FL_NO_SIG}
    image_kind_t;

  typedef struct packed {
    logic       is_mine;
    logic       msb_first;
    logic       key_present;
    logic [7:0] pilot_val;
    logic [7:0] sync_byte;
  } verdict_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  lsr_in_if in_ch();
  lsr_out_if out_ch();

  loader_signature_recognizer uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_ch),
    .out_ch(out_ch)
  );

  always #5 clk = ~clk;

  verdict_t verdict_q[$];
  int errors = 0;
  int cycles = 0;
  int tx_idle = 0;
  int rx_idle = 0;
  int hold_cycles = 0;
  int filled = 0;

  // Predictor state.
  bit [7:0] store_img [0:65535];
  bit [15:0] wr_ptr = 16'd0;
  logic [1:0] status = ST_NOT_CHECKED;
  bit pr_msb = 1'b1;
  bit pr_key = 1'b1;
  bit [7:0] pr_pilot = 8'h00;
  bit [7:0] pr_sync = 8'h3d;
  bit [7:0] xor_key = 8'h00;

  bit [7:0] image [0:1023];
  bit [7:0] key_set [0:23] = '{8'h98, 8'he8, 8'h60, 8'h08, 8'h98, 8'hec, 8'hb4,
    8'h04, 8'h08, 8'h24, 8'he8, 8'hc0, 8'h28, 8'h24, 8'h80, 8'hc0, 8'hbc, 8'he0,
    8'ha4, 8'hc0, 8'he0, 8'ha4, 8'h40, 8'h80};

  function automatic bit [7:0] peek(int off);
    return store_img[off % 65536];
  endfunction

  function automatic bit key_window_hit();
    bit [7:0] v;
    for (int p = 234; p <= 402; p++) begin
      v = peek(p + 18);
      if (peek(p) == 8'had && peek(p + 1) == 8'h00 && peek(p + 2) == 8'h80 &&
          peek(p + 3) == 8'hee && peek(p + 4) == 8'h00 && peek(p + 5) == 8'h80 &&
          peek(p + 6) == 8'hcd && peek(p + 7) == 8'h00 && peek(p + 8) == 8'h80 &&
          peek(p + 9) == 8'h26 && peek(p + 11) == 8'h68 && peek(p + 12) == 8'hc9 &&
          peek(p + 13) == 8'h61 && peek(p + 14) == 8'hf0 && peek(p + 15) == 8'h01 &&
          peek(p + 16) == 8'h18 && peek(p + 17) == 8'h26 && v >= KEY_LOW &&
          v <= KEY_HIGH && v == peek(p + 20) && v == peek(p + 10) &&
          peek(p + 19) == 8'ha5) begin
        xor_key = key_set[v - KEY_LOW];
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic bit decode_hit(int len);
    bit [7:0] k, m, kb;
    bit msb, kp;
    int kpos;
    k = xor_key;
    for (int p = 423; p < len - 23; p++) begin
      if (!((peek(p) ^ k) == 8'hc9 && peek(p + 1) == peek(p + 19) &&
            (peek(p + 2) ^ k) == 8'hd0 && (peek(p + 4) ^ k) == 8'ha2 &&
            (peek(p + 6) ^ k) == 8'h86 && (peek(p + 7) ^ k) == 8'hff &&
            (peek(p + 8) ^ k) == 8'ha9 && (peek(p + 10) ^ k) == 8'hd0 &&
            (peek(p + 12) ^ k) == 8'h90 && (peek(p + 14) ^ k) == 8'ha2 &&
            peek(p + 15) == peek(p + 5) && (peek(p + 16) ^ k) == 8'h86 &&
            (peek(p + 17) ^ k) == 8'hff && (peek(p + 18) ^ k) == 8'hc9 &&
            (peek(p + 20) ^ k) == 8'hf0 && (peek(p + 22) ^ k) == 8'hc9))
        continue;
      m = peek(p + 5) ^ k;
      if (m == ORDER_MSB) begin
        msb = 1'b1;
        kpos = p + 30;
      end else if (m == ORDER_LSB) begin
        msb = 1'b0;
        kpos = p + 29;
      end else continue;
      kb = peek(kpos) ^ k;
      if (kb == KEY_BYTE_YES) kp = 1'b1;
      else if (kb == KEY_BYTE_NO) kp = 1'b0;
      else continue;
      pr_msb = msb;
      pr_key = kp;
      pr_pilot = peek(p + 1) ^ k;
      pr_sync = peek(p + 23) ^ k;
      status = ST_CHECKED;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic bit recognise(logic [15:0] s, logic [15:0] e);
    if (status == ST_CHECKED) return 1'b1;
    if (status == ST_END_FOUND) return 1'b0;
    if (s != BLOCK_START || e < BLOCK_MIN_END) return 1'b0;
    if (!key_window_hit()) return 1'b0;
    return decode_hit(int'(e) - int'(s));
  endfunction

  function automatic void predict(bit m, logic [15:0] s, logic [15:0] e,
                                  logic [7:0] d, bit l);
    verdict_t r;
    if (m) begin
      wr_ptr = 16'd0;
      if (s == END_MARK_START && e == END_MARK_END) status = ST_END_FOUND;
      return;
    end
    store_img[wr_ptr] = d;
    wr_ptr = wr_ptr + 16'd1;
    if (int'(wr_ptr) > filled) filled = int'(wr_ptr);
    if (!l) return;
    wr_ptr = 16'd0;
    r = '0;
    if (recognise(s, e)) r = '{1'b1, pr_msb, pr_key, pr_pilot, pr_sync};
    verdict_q.push_back(r);
  endfunction

  task automatic send_item(bit m, logic [15:0] s, logic [15:0] e, logic [7:0] d,
                           bit l);
    @(negedge clk);
    while ($urandom_range(0, 99) < tx_idle) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.mode = m;
    in_ch.block_start = s;
    in_ch.block_end = e;
    in_ch.data_byte = d;
    in_ch.last = l;
    in_ch.valid = 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    predict(m, s, e, d, l);
  endtask

  task automatic drain();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (verdict_q.size() > 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic send_image(int n, logic [15:0] s, logic [15:0] e);
    for (int i = 0; i < n; i++) send_item(1'b0, s, e, image[i], i == n - 1);
  endtask

  task automatic build_image(int n, image_kind_t kind);
    bit [7:0] v, k, a, m, kb;
    int p, q;
    bit msb;
    for (int i = 0; i < n; i++) image[i] = 8'($urandom);
    if (kind == FL_NO_SIG) return;
    p = $urandom_range(234, 402);
    case ($urandom_range(0, 2))
      0: v = KEY_LOW;
      1: v = KEY_HIGH;
      default: v = 8'($urandom_range(KEY_LOW, KEY_HIGH));
    endcase
    if (kind == FL_BAD_V) v = $urandom_range(0, 1) ? KEY_LOW - 8'd1 : KEY_HIGH + 8'd1;
    k = (kind == FL_BAD_V) ? 8'h00 : key_set[v - KEY_LOW];
    {image[p], image[p + 1], image[p + 2], image[p + 3], image[p + 4]} =
      {8'had, 8'h00, 8'h80, 8'hee, 8'h00};
    {image[p + 5], image[p + 6], image[p + 7], image[p + 8], image[p + 9]} =
      {8'h80, 8'hcd, 8'h00, 8'h80, 8'h26};
    {image[p + 11], image[p + 12], image[p + 13], image[p + 14]} =
      {8'h68, 8'hc9, 8'h61, 8'hf0};
    {image[p + 15], image[p + 16], image[p + 17], image[p + 19]} =
      {8'h01, 8'h18, 8'h26, 8'ha5};
    image[p + 10] = v;
    image[p + 18] = v;
    image[p + 20] = v;
    q = $urandom_range(423, 430);
    a = 8'($urandom);
    msb = $urandom_range(0, 1);
    m = msb ? ORDER_MSB : ORDER_LSB;
    if (kind == FL_BAD_ORDER) m = 8'h02;
    kb = $urandom_range(0, 1) ? KEY_BYTE_YES : KEY_BYTE_NO;
    if (kind == FL_BAD_KEYBYTE) kb = 8'h09;
    image[q] = 8'hc9 ^ k;
    image[q + 1] = a;
    image[q + 19] = a;
    image[q + 2] = 8'hd0 ^ k;
    image[q + 4] = 8'ha2 ^ k;
    image[q + 5] = m ^ k;
    image[q + 15] = m ^ k;
    image[q + 6] = 8'h86 ^ k;
    image[q + 7] = 8'hff ^ k;
    image[q + 8] = 8'ha9 ^ k;
    image[q + 10] = 8'hd0 ^ k;
    image[q + 12] = 8'h90 ^ k;
    image[q + 14] = 8'ha2 ^ k;
    image[q + 16] = 8'h86 ^ k;
    image[q + 17] = 8'hff ^ k;
    image[q + 18] = 8'hc9 ^ k;
    image[q + 20] = 8'hf0 ^ k;
    image[q + 22] = 8'hc9 ^ k;
    image[msb ? q + 30 : q + 29] = kb ^ k;
  endtask

  // A short block or a header event with random fields; a scan is only
  // allowed where every byte it can read has been written.
  task automatic send_noise();
    logic [15:0] s, e;
    int n;
    s = $urandom_range(0, 99) < 40 ? BLOCK_START : 16'($urandom);
    e = 16'($urandom);
    if (s == BLOCK_START && status == ST_NOT_CHECKED)
      e = $urandom_range(0, 1) ? 16'($urandom_range(0, BLOCK_MIN_END - 1)) :
          16'($urandom_range(BLOCK_MIN_END, BLOCK_START + filled - 7));
    if ($urandom_range(0, 99) < 15) begin
      if (s == END_MARK_START && e == END_MARK_END) e = 16'hffff;
      send_item(1'b1, s, e, 8'($urandom), $urandom_range(0, 1));
    end else begin
      n = $urandom_range(1, 6);
      for (int i = 0; i < n; i++) send_item(1'b0, s, e, 8'($urandom), i == n - 1);
    end
  endtask

  task automatic test_directed();
    send_item(1'b1, 16'h0000, 16'h0000, 8'hff, 1'b1);
    send_item(1'b1, 16'hffff, 16'hffff, 8'h00, 1'b0);
    send_item(1'b1, END_MARK_START, 16'hffff, 8'h5a, 1'b0);
    send_item(1'b1, 16'hfffd, END_MARK_END, 8'ha5, 1'b1);
    send_item(1'b0, 16'hffff, 16'hffff, 8'hff, 1'b1);
    send_item(1'b0, 16'h0000, 16'h0000, 8'h00, 1'b1);
    send_item(1'b0, BLOCK_START, BLOCK_MIN_END - 16'd1, 8'h00, 1'b0);
    send_item(1'b0, BLOCK_START, BLOCK_MIN_END - 16'd1, 8'hff, 1'b1);
    send_item(1'b0, BLOCK_START + 16'd1, 16'hffff, 8'h80, 1'b1);
    send_item(1'b0, 16'h0000, 16'h0000, 8'h01, 1'b0);
    send_item(1'b1, 16'h1234, 16'h5678, 8'h00, 1'b0);
    send_item(1'b0, 16'hcee9, 16'h3116, 8'h7f, 1'b1);
  endtask

  task automatic test_near_miss_fill();
    image_kind_t kind;
    kind = image_kind_t'($urandom_range(FL_BAD_V, FL_NO_SIG));
    build_image(FILL_BYTES, kind);
    send_image(FILL_BYTES, BLOCK_START, BLOCK_MIN_END);
    drain();
  endtask

  task automatic test_noise_blocks(int count);
    for (int i = 0; i < count; i++) send_noise();
  endtask

  task automatic test_backpressure();
    logic [15:0] s;
    drain();
    @(posedge clk);
    hold_cycles = 400;
    for (int i = 0; i < 8; i++) begin
      s = 16'($urandom);
      if (s == BLOCK_START) s = 16'h0000;
      send_item(1'b0, s, 16'($urandom), 8'($urandom), 1'b1);
    end
    drain();
  endtask

  task automatic test_match();
    int e;
    build_image(IMG_BYTES, FL_MATCH);
    e = $urandom_range(BLOCK_MIN_END, BLOCK_START + filled - 7);
    send_image(IMG_BYTES, BLOCK_START, 16'(e));
  endtask

  task automatic test_end_marker();
    send_item(1'b1, END_MARK_START, END_MARK_END, 8'($urandom), 1'b1);
    test_noise_blocks(4);
  endtask

  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_ch.ready = 1'b0;
      hold_cycles = hold_cycles - 1;
    end else begin
      out_ch.ready = ($urandom_range(0, 99) >= rx_idle);
    end
  end

  always @(posedge clk) begin
    verdict_t want, got;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = '{out_ch.is_mine, out_ch.msb_first, out_ch.key_present,
              out_ch.pilot_val, out_ch.sync_byte};
      if (verdict_q.size() == 0) begin
        $display("%0t: unexpected result expected none actual %h", $time, got);
        errors++;
      end else begin
        want = verdict_q.pop_front();
        if (got != want) begin
          $display("%0t: mismatch expected %h actual %h", $time, want, got);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.mode = 1'b0;
    in_ch.block_start = 16'h0000;
    in_ch.block_end = 16'h0000;
    in_ch.data_byte = 8'h00;
    in_ch.last = 1'b0;
    out_ch.ready = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_directed();
    tx_idle = 28;
    rx_idle = 51;
    test_near_miss_fill();
    test_noise_blocks(5);
    test_backpressure();
    tx_idle = 51;
    rx_idle = 28;
    test_match();
    test_noise_blocks(5);
    tx_idle = 0;
    rx_idle = 0;
    test_noise_blocks(4);
    test_end_marker();
    drain();
    repeat (100) @(posedge clk);
    if (errors == 0 && verdict_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+hdl
hdl/lsr_pkg.sv
hdl/lsr_if.sv
hdl/lsr_front.sv
hdl/lsr_queue.sv
hdl/lsr_back.sv
hdl/loader_signature_recognizer.sv
bench/tb_loader_signature_recognizer.sv
